// ===== sv/mrc_pkg.sv =====
package mrc_pkg;

    // Buffer length bound and the counter width that follows from it.
    localparam int MAX_BUFFER_BYTES = 256;
    localparam int TOTAL_W = $clog2(MAX_BUFFER_BYTES + 1);

    // The frame position saturates at its own fixed bound.
    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = 9'd511;
    localparam logic [POS_W-1:0] POS_COUNT = 9'd2;
    localparam int NEED_W = 9;
    localparam logic [NEED_W-1:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [NEED_W-1:0] CRC_BYTES = 9'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int ECHO_LEN = 8;
    localparam int ECHO_IDX_W = 3;
    localparam int JUNK_LIMIT = 20;
    localparam int TEMP_OFFSET = 400;

    localparam logic [7:0] POLL_CMD [ECHO_LEN] = '{
        8'h09, 8'h03, 8'h00, 8'hFD, 8'h00, 8'h1C, 8'hD4, 8'hBB
    };

    // Frame offsets captured for decoding: signal, height, smooth, temperature, tilt.
    localparam int CAP_SLOTS = 8;
    localparam logic [POS_W-1:0] CAP_POS [CAP_SLOTS] = '{
        9'd6, 9'd8, 9'd9, 9'd10, 9'd11, 9'd12, 9'd13, 9'd14
    };

    // Reset values of the configuration registers.
    localparam logic [7:0] DEV_ADDR_RST = 8'h09;
    localparam logic [7:0] FUNC_CODE_RST = 8'h03;
    localparam logic [7:0] DECODE_COUNT_RST = 8'd56;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_BYTE_COUNT = 2'd2;

    // Reply classes.
    localparam logic [2:0] CLS_SILENCE = 3'd0;
    localparam logic [2:0] CLS_ECHO = 3'd1;
    localparam logic [2:0] CLS_VALID = 3'd2;
    localparam logic [2:0] CLS_LONG_JUNK = 3'd3;
    localparam logic [2:0] CLS_OVER_CMD = 3'd4;
    localparam logic [2:0] CLS_SHORT_JUNK = 3'd5;

    // One byte of the Modbus CRC-16, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/mrc_in_if.sv =====
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, has_byte, data_byte, last, input ready);
    modport sink (input valid, has_byte, data_byte, last, output ready);
endinterface

// ===== sv/mrc_out_if.sv =====
interface mrc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         reply_class;
    logic [7:0]         payload_count;
    logic               decoded;
    logic [7:0]         signal_level;
    logic [15:0]        height_tenths;
    logic [15:0]        smooth_tenths;
    logic signed [16:0] temp_tenths;
    logic [7:0]         tilt_degrees;

    modport source (
        output valid, reply_class, payload_count, decoded, signal_level,
               height_tenths, smooth_tenths, temp_tenths, tilt_degrees,
        input  ready
    );
    modport sink (
        input  valid, reply_class, payload_count, decoded, signal_level,
               height_tenths, smooth_tenths, temp_tenths, tilt_degrees,
        output ready
    );
endinterface

// ===== sv/modbus_reply_checker_unit.sv =====
// Channel   Dir  Handshake            Payload
// i_in      in   valid/ready          has_byte, data_byte, last
// o_res     out  valid/ready          reply_class, payload_count, decoded, fields
// i_cfg_*   in   i_cfg_we, no wait    i_cfg_index, i_cfg_data
//
// One item is taken every cycle unless a waiting result stalls it; an item passes
// an input register, then the header hunt, CRC byte update and capture logic,
// and the result of a buffer's last item lands in the output register as that
// item is taken. Synchronous active-low reset clears the buffer state and loads
// the register defaults. A result waiting at the output stalls only a following item that ends a buffer.
module modbus_reply_checker_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    mrc_in_if.sink                          i_in,
    mrc_out_if.source                       o_res
);

    typedef enum logic [1:0] {PH_SEARCH, PH_ADDR, PH_FRAME, PH_DONE} t_phase;
    typedef enum logic [1:0] {ST_NONE, ST_PENDING, ST_VALID, ST_BAD} t_status;

    localparam int TW = mrc_pkg::TOTAL_W;
    localparam int PW = mrc_pkg::POS_W;
    localparam int NW = mrc_pkg::NEED_W;

    // Configuration.
    logic [7:0] r_dev_addr;
    logic [7:0] r_func_code;
    logic [7:0] r_decode_count;

    // Input register.
    logic       r_in_valid;
    logic       r_in_has;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Buffer state.
    logic [TW-1:0] r_total, n_total;
    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [NW-1:0] r_need, n_need;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_crc_low, n_crc_low;
    t_status       r_status, n_status;
    logic          r_echo, n_echo;
    logic [7:0]    r_cap [mrc_pkg::CAP_SLOTS];
    logic [7:0]    n_cap [mrc_pkg::CAP_SLOTS];

    // Result register.
    logic               r_out_valid;
    logic [2:0]         r_cls, n_cls;
    logic [7:0]         r_count, n_count;
    logic               r_dec, n_dec;
    logic [7:0]         r_sig, n_sig;
    logic [15:0]        r_height, n_height;
    logic [15:0]        r_smooth, n_smooth;
    logic signed [16:0] r_temp, n_temp;
    logic [7:0]         r_tilt, n_tilt;

    logic          w_take;
    logic          w_byte_ok;
    logic [15:0]   w_crc_next;
    logic [NW-1:0] w_need;
    logic [NW-1:0] w_crc_pos;
    logic [15:0]   w_got;

    assign w_take = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_take;
    assign w_byte_ok = r_in_valid && r_in_has
                       && (r_total < TW'(mrc_pkg::MAX_BUFFER_BYTES));

    // A header restart seeds the CRC from its init value; otherwise it runs on.
    assign w_crc_next = mrc_pkg::crc_feed((r_phase == PH_SEARCH) ? mrc_pkg::CRC_INIT : r_crc,
                                          r_in_byte);
    assign w_need = (r_pos == mrc_pkg::POS_COUNT)
                    ? (NW'(r_in_byte) + mrc_pkg::FRAME_OVERHEAD) : r_need;
    assign w_crc_pos = w_need - mrc_pkg::CRC_BYTES;
    assign w_got = {r_in_byte, r_crc_low};

    always_comb begin
        n_total   = r_total;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_need    = r_need;
        n_crc     = r_crc;
        n_crc_low = r_crc_low;
        n_status  = r_status;
        n_echo    = r_echo;
        n_cap     = r_cap;
        if (w_byte_ok) begin
            if (r_total >= TW'(mrc_pkg::ECHO_LEN)
                || r_in_byte != mrc_pkg::POLL_CMD[r_total[mrc_pkg::ECHO_IDX_W-1:0]]) begin
                n_echo = 1'b0;
            end
            case (r_phase)
                PH_SEARCH: begin
                    if (r_in_byte == r_dev_addr) begin
                        n_phase = PH_ADDR;
                        n_crc   = w_crc_next;
                    end
                end
                PH_ADDR: begin
                    if (r_in_byte == r_func_code) begin
                        n_phase  = PH_FRAME;
                        n_status = ST_PENDING;
                        n_crc    = w_crc_next;
                        n_pos    = mrc_pkg::POS_COUNT;
                    end else if (r_in_byte != r_dev_addr) begin
                        n_phase = PH_SEARCH;
                    end
                end
                default: begin
                    if (r_phase == PH_FRAME) begin
                        n_need = w_need;
                        if (NW'(r_pos) < w_crc_pos) begin
                            n_crc = w_crc_next;
                        end else if (NW'(r_pos) == w_crc_pos) begin
                            n_crc_low = r_in_byte;
                        end else begin
                            n_status = (w_got == r_crc) ? ST_VALID : ST_BAD;
                            n_phase  = PH_DONE;
                        end
                    end
                    for (int k = 0; k < mrc_pkg::CAP_SLOTS; k++) begin
                        if (r_pos == mrc_pkg::CAP_POS[k]) begin
                            n_cap[k] = r_in_byte;
                        end
                    end
                    if (r_pos != mrc_pkg::POS_MAX) begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            endcase
            n_total = r_total + TW'(1);
        end
    end

    // Classification of the closed buffer, first match wins.
    always_comb begin
        if (n_total == '0) begin
            n_cls = mrc_pkg::CLS_SILENCE;
        end else if (n_echo && n_total == TW'(mrc_pkg::ECHO_LEN)) begin
            n_cls = mrc_pkg::CLS_ECHO;
        end else if (n_status == ST_VALID) begin
            n_cls = mrc_pkg::CLS_VALID;
        end else if (n_total >= TW'(mrc_pkg::JUNK_LIMIT)) begin
            n_cls = mrc_pkg::CLS_LONG_JUNK;
        end else if (n_total > TW'(mrc_pkg::ECHO_LEN)) begin
            n_cls = mrc_pkg::CLS_OVER_CMD;
        end else begin
            n_cls = mrc_pkg::CLS_SHORT_JUNK;
        end
        n_count = '0;
        if (n_cls == mrc_pkg::CLS_VALID) begin
            n_count = 8'(n_need - mrc_pkg::FRAME_OVERHEAD);
        end
        n_dec = (n_cls == mrc_pkg::CLS_VALID) && (n_count == r_decode_count);
        n_sig    = '0;
        n_height = '0;
        n_smooth = '0;
        n_temp   = '0;
        n_tilt   = '0;
        if (n_dec) begin
            n_sig    = n_cap[0];
            n_height = {n_cap[1], n_cap[2]};
            n_smooth = {n_cap[3], n_cap[4]};
            n_temp   = signed'({1'b0, n_cap[5], n_cap[6]}) - 17'sd400;
            n_tilt   = n_cap[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr     <= mrc_pkg::DEV_ADDR_RST;
            r_func_code    <= mrc_pkg::FUNC_CODE_RST;
            r_decode_count <= mrc_pkg::DECODE_COUNT_RST;
            r_in_valid     <= 1'b0;
            r_total        <= '0;
            r_phase        <= PH_SEARCH;
            r_pos          <= '0;
            r_need         <= '0;
            r_crc          <= mrc_pkg::CRC_INIT;
            r_crc_low      <= '0;
            r_status       <= ST_NONE;
            r_echo         <= 1'b1;
            for (int k = 0; k < mrc_pkg::CAP_SLOTS; k++) begin
                r_cap[k] <= '0;
            end
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrc_pkg::REG_DEVICE_ADDRESS:    r_dev_addr     <= i_cfg_data;
                    mrc_pkg::REG_FUNCTION_CODE:     r_func_code    <= i_cfg_data;
                    mrc_pkg::REG_DECODE_BYTE_COUNT: r_decode_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end

            if (w_take && r_in_last) begin
                // The buffer is closed: hand over its result and start afresh.
                r_out_valid <= 1'b1;
                r_total     <= '0;
                r_phase     <= PH_SEARCH;
                r_pos       <= '0;
                r_need      <= '0;
                r_crc       <= mrc_pkg::CRC_INIT;
                r_crc_low   <= '0;
                r_status    <= ST_NONE;
                r_echo      <= 1'b1;
                for (int k = 0; k < mrc_pkg::CAP_SLOTS; k++) begin
                    r_cap[k] <= '0;
                end
            end else begin
                if (o_res.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (w_take) begin
                    r_total   <= n_total;
                    r_phase   <= n_phase;
                    r_pos     <= n_pos;
                    r_need    <= n_need;
                    r_crc     <= n_crc;
                    r_crc_low <= n_crc_low;
                    r_status  <= n_status;
                    r_echo    <= n_echo;
                    r_cap     <= n_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_has  <= i_in.has_byte;
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
        if (w_take && r_in_last) begin
            r_cls    <= n_cls;
            r_count  <= n_count;
            r_dec    <= n_dec;
            r_sig    <= n_sig;
            r_height <= n_height;
            r_smooth <= n_smooth;
            r_temp   <= n_temp;
            r_tilt   <= n_tilt;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.reply_class   = r_cls;
    assign o_res.payload_count = r_count;
    assign o_res.decoded       = r_dec;
    assign o_res.signal_level  = r_sig;
    assign o_res.height_tenths = r_height;
    assign o_res.smooth_tenths = r_smooth;
    assign o_res.temp_tenths   = r_temp;
    assign o_res.tilt_degrees  = r_tilt;

endmodule
